// File: rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package qrs_pkg;

  // Zero tolerance register
  localparam int TOL_W = 16;
  localparam logic [15:0] TOL_RESET = 16'd1;

  // Configuration bus
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_ZERO_TOL = 3'd0;

  // Which formula produces the roots of one request
  typedef enum logic [2:0] {
    CASE_NONE,     // no real roots
    CASE_INF,      // every x is a root
    CASE_ZERO1,    // single root at zero
    CASE_ZERO_BA,  // roots zero and -b/a
    CASE_LIN,      // single root -c/b
    CASE_DOUBLE,   // double root -b/(2a)
    CASE_TWO       // two roots (-b +- s)/(2a)
  } case_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_INF  = 2'd3
  } kind_e;

  function automatic kind_e kind_of(case_e c);
    kind_e k;
    unique case (c)
      CASE_INF:                          k = KIND_INF;
      CASE_ZERO1, CASE_LIN, CASE_DOUBLE: k = KIND_ONE;
      CASE_ZERO_BA, CASE_TWO:            k = KIND_TWO;
      default:                           k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic use_first(case_e c);
    return (c == CASE_LIN) || (c == CASE_DOUBLE) || (c == CASE_TWO);
  endfunction

  function automatic logic use_second(case_e c);
    return (c == CASE_ZERO_BA) || (c == CASE_TWO);
  endfunction

endpackage

// File: rtl/qrs_coef_if.sv
// Request channel carrying the three coefficients.
// Stand-alone; no dependencies.
`timescale 1ns / 1ps

interface qrs_coef_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_square;
  logic signed [W-1:0] coef_linear;
  logic signed [W-1:0] coef_constant;

  modport source (output valid, coef_square, coef_linear, coef_constant, input ready);
  modport sink   (input valid, coef_square, coef_linear, coef_constant, output ready);
endinterface

// File: rtl/qrs_root_if.sv
// Result channel carrying root count, roots and saturation flag.
// Stand-alone; no dependencies.
`timescale 1ns / 1ps

interface qrs_root_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          root_kind;
  logic signed [W-1:0] first_root;
  logic signed [W-1:0] second_root;
  logic                saturated;

  modport source (output valid, root_kind, first_root, second_root, saturated, input ready);
  modport sink   (input valid, root_kind, first_root, second_root, saturated, output ready);
endinterface

// File: rtl/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: front end, square root chain,
// two divider chains and output register. Uses qrs_pkg, the two channel
// interfaces, qrs_sqrt_cell and qrs_div_cell.
//
// Usage:
//   coef_i carries a request of coefficients a, b, c (signed, FRAC_BITS
//   fraction bits); root_o returns one result per request in order: root
//   count, two roots and a saturation flag. Both use valid/ready.
//   The APB port holds the zero tolerance at byte address 0; write it only
//   while no request is in flight.
// Timing:
//   One request per cycle sustained while results are taken. The depth is
//   set by the length of the square root chain (one root bit per cell) and
//   of the divider chains (one quotient bit per cell).
// Reset:
//   Clears all valid bits and sets the tolerance to 1; no clearing pass.
// Stall:
//   While a result waits unaccepted in the output register the whole pipeline
//   holds and coef_i.ready is low; it resumes the cycle the result is taken.
`timescale 1ns / 1ps

module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [qrs_pkg::APB_AW-1:0]  paddr_i,
  input  logic [qrs_pkg::APB_DW-1:0]  pwdata_i,
  output logic [qrs_pkg::APB_DW-1:0]  prdata_o,
  output logic                        pready_o,
  qrs_coef_if.sink                    coef_i,
  qrs_root_if.source                  root_o
);
  localparam int W      = COEF_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int L      = W / 2;
  localparam int H      = W - L;
  localparam int LL2    = 2 * L;
  localparam int HH2    = 2 * H;
  localparam int BW     = 2 * W;
  localparam int SW     = W + 1;
  localparam int DW     = 2 * SW;
  localparam int RW     = SW + 1;
  localparam int TDW    = qrs_pkg::TOL_W + F;
  localparam int XW     = (DW > TDW) ? DW : TDW;
  localparam int NW     = W + 3;
  localparam int DNW    = W + 2;
  localparam int MW     = W + 2;
  localparam int DMW    = W + 1;
  localparam int QW     = MW + F;
  localparam int STAG_W = 3 * W + 3;
  localparam int TAG1_W = 4;
  localparam int NST    = 6 + SW + 2 + QW;

  // ---------------------------------------------------------------- config
  logic [qrs_pkg::TOL_W-1:0] tol_q;

  // Write the tolerance on the access phase of an APB write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qrs_pkg::TOL_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 (paddr_i == qrs_pkg::ADDR_ZERO_TOL)) begin
      tol_q <= pwdata_i[qrs_pkg::TOL_W-1:0];
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == qrs_pkg::ADDR_ZERO_TOL) ? qrs_pkg::APB_DW'(tol_q) : '0;

  // -------------------------------------------------------------- control
  logic           en;
  logic [NST-1:0] vld_q;
  logic           out_vld_q;

  // Hold everything while the output request is stalled
  assign en           = !out_vld_q || root_o.ready;
  assign coef_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NST-2:0], coef_i.valid};
      out_vld_q <= vld_q[NST-1];
    end
  end

  // ------------------------------------------------------ stage 1: capture
  logic signed [W-1:0] a1_q, b1_q, c1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= coef_i.coef_square;
      b1_q <= coef_i.coef_linear;
      c1_q <= coef_i.coef_constant;
    end
  end

  // --------------------------------------- stage 2: magnitudes, zero tests
  logic signed [W-1:0] a2_q, b2_q, c2_q;
  logic [W-1:0]        ma2_q, mb2_q, mc2_q;
  logic                za2_q, zb2_q, zc2_q;
  logic [W-1:0]        ma_d, mb_d, mc_d, tolw;

  assign ma_d = a1_q[W-1] ? W'(-a1_q) : W'(a1_q);
  assign mb_d = b1_q[W-1] ? W'(-b1_q) : W'(b1_q);
  assign mc_d = c1_q[W-1] ? W'(-c1_q) : W'(c1_q);
  assign tolw = W'(tol_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      c2_q  <= c1_q;
      ma2_q <= ma_d;
      mb2_q <= mb_d;
      mc2_q <= mc_d;
      za2_q <= (ma_d == '0) || (ma_d < tolw);
      zb2_q <= (mb_d == '0) || (mb_d < tolw);
      zc2_q <= (mc_d == '0) || (mc_d < tolw);
    end
  end

  // ---------------------------------------- stage 3: half-width products
  logic signed [W-1:0] a3_q, b3_q, c3_q;
  logic                za3_q, zb3_q, zc3_q, sdiff3_q;
  logic [LL2-1:0]      bb_ll_q, ac_ll_q;
  logic [W-1:0]        bb_lh_q, ac_lh_q, ac_hl_q;
  logic [HH2-1:0]      bb_hh_q, ac_hh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q     <= a2_q;
      b3_q     <= b2_q;
      c3_q     <= c2_q;
      za3_q    <= za2_q;
      zb3_q    <= zb2_q;
      zc3_q    <= zc2_q;
      sdiff3_q <= a2_q[W-1] ^ c2_q[W-1];
      bb_ll_q  <= LL2'(mb2_q[L-1:0]) * LL2'(mb2_q[L-1:0]);
      bb_lh_q  <= W'(mb2_q[W-1:L]) * W'(mb2_q[L-1:0]);
      bb_hh_q  <= HH2'(mb2_q[W-1:L]) * HH2'(mb2_q[W-1:L]);
      ac_ll_q  <= LL2'(ma2_q[L-1:0]) * LL2'(mc2_q[L-1:0]);
      ac_lh_q  <= W'(ma2_q[W-1:L]) * W'(mc2_q[L-1:0]);
      ac_hl_q  <= W'(ma2_q[L-1:0]) * W'(mc2_q[W-1:L]);
      ac_hh_q  <= HH2'(ma2_q[W-1:L]) * HH2'(mc2_q[W-1:L]);
    end
  end

  // ------------------------------------------- stage 4: b*b and 4*a*c
  logic signed [W-1:0] a4_q, b4_q, c4_q;
  logic                za4_q, zb4_q, zc4_q, sdiff4_q;
  logic [BW-1:0]       bb4_q;
  logic [DW-1:0]       ac4_q;
  logic [BW-1:0]       bb_d, ac_d;

  assign bb_d = (BW'(bb_hh_q) << LL2) + (BW'(bb_lh_q) << (L + 1)) + BW'(bb_ll_q);
  assign ac_d = (BW'(ac_hh_q) << LL2) + ((BW'(ac_lh_q) + BW'(ac_hl_q)) << L) +
                BW'(ac_ll_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_q     <= a3_q;
      b4_q     <= b3_q;
      c4_q     <= c3_q;
      za4_q    <= za3_q;
      zb4_q    <= zb3_q;
      zc4_q    <= zc3_q;
      sdiff4_q <= sdiff3_q;
      bb4_q    <= bb_d;
      ac4_q    <= {ac_d, 2'b00};
    end
  end

  // ------------------------------------ stage 5: discriminant magnitude
  logic signed [W-1:0] a5_q, b5_q, c5_q;
  logic                za5_q, zb5_q, zc5_q, dpos5_q;
  logic [DW-1:0]       dm5_q;
  logic [DW-1:0]       bbx;

  assign bbx = DW'(bb4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a5_q  <= a4_q;
      b5_q  <= b4_q;
      c5_q  <= c4_q;
      za5_q <= za4_q;
      zb5_q <= zb4_q;
      zc5_q <= zc4_q;
      priority if (sdiff4_q) begin
        dm5_q   <= bbx + ac4_q;
        dpos5_q <= 1'b1;
      end else if (bbx >= ac4_q) begin
        dm5_q   <= bbx - ac4_q;
        dpos5_q <= 1'b1;
      end else begin
        dm5_q   <= ac4_q - bbx;
        dpos5_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------- stage 6: pick the formula
  logic signed [W-1:0] a6_q, b6_q, c6_q;
  logic [DW-1:0]       dm6_q;
  qrs_pkg::case_e      case6_q, case_d;
  logic [XW-1:0]       tol_dx, dm_x;
  logic                dzero;

  assign tol_dx = XW'(tol_q) << F;
  assign dm_x   = XW'(dm5_q);
  assign dzero  = (dm5_q == '0) || (dm_x < tol_dx);

  always_comb begin
    priority if (za5_q || zc5_q) begin
      priority if (zc5_q && za5_q) begin
        case_d = zb5_q ? qrs_pkg::CASE_INF : qrs_pkg::CASE_ZERO1;
      end else if (zc5_q) begin
        case_d = zb5_q ? qrs_pkg::CASE_ZERO1 : qrs_pkg::CASE_ZERO_BA;
      end else begin
        case_d = zb5_q ? qrs_pkg::CASE_NONE : qrs_pkg::CASE_LIN;
      end
    end else if (dzero) begin
      case_d = qrs_pkg::CASE_DOUBLE;
    end else if (dpos5_q) begin
      case_d = qrs_pkg::CASE_TWO;
    end else begin
      case_d = qrs_pkg::CASE_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a6_q    <= a5_q;
      b6_q    <= b5_q;
      c6_q    <= c5_q;
      dm6_q   <= dm5_q;
      case6_q <= case_d;
    end
  end

  // ------------------------------------------------ square root chain
  logic [RW-1:0]     sq_rem  [SW+1];
  logic [SW-1:0]     sq_root [SW+1];
  logic [DW-1:0]     sq_d    [SW+1];
  logic [STAG_W-1:0] sq_tag  [SW+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_d[0]    = dm6_q;
  assign sq_tag[0]  = {a6_q, b6_q, c6_q, case6_q};

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(
      .SW    (SW),
      .TAG_W (STAG_W)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .d_i    (sq_d[k]),
      .tag_i  (sq_tag[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .d_o    (sq_d[k+1]),
      .tag_o  (sq_tag[k+1])
    );
  end

  // ------------------------------- post 1: numerators and denominators
  logic signed [W-1:0]   pa, pb, pc;
  qrs_pkg::case_e        pcase;
  logic signed [NW-1:0]  nb, nc, sx, n1_d, n2_d, n1_q, n2_q;
  logic signed [DNW-1:0] a2x, ax, bx, d1_d, d2_d, d1_q, d2_q;
  qrs_pkg::case_e        case_p1_q;

  assign pa    = sq_tag[SW][STAG_W-1 -: W];
  assign pb    = sq_tag[SW][STAG_W-W-1 -: W];
  assign pc    = sq_tag[SW][STAG_W-2*W-1 -: W];
  assign pcase = qrs_pkg::case_e'(sq_tag[SW][2:0]);
  assign nb    = -NW'(pb);
  assign nc    = -NW'(pc);
  assign sx    = signed'(NW'(sq_root[SW]));
  assign ax    = DNW'(pa);
  assign a2x   = ax <<< 1;
  assign bx    = DNW'(pb);

  always_comb begin
    unique case (pcase)
      qrs_pkg::CASE_LIN: begin
        n1_d = nc;
        d1_d = bx;
      end
      qrs_pkg::CASE_TWO: begin
        n1_d = nb + sx;
        d1_d = a2x;
      end
      default: begin
        n1_d = nb;
        d1_d = a2x;
      end
    endcase
    unique case (pcase)
      qrs_pkg::CASE_ZERO_BA: begin
        n2_d = nb;
        d2_d = ax;
      end
      qrs_pkg::CASE_TWO: begin
        n2_d = nb - sx;
        d2_d = a2x;
      end
      default: begin
        n2_d = nb;
        d2_d = a2x;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q      <= n1_d;
      d1_q      <= d1_d;
      n2_q      <= n2_d;
      d2_q      <= d2_d;
      case_p1_q <= pcase;
    end
  end

  // --------------------------------- post 2: magnitudes and quotient sign
  logic [MW-1:0]  nm1_q, nm2_q;
  logic [DMW-1:0] dm1_q, dm2_q;
  logic           neg1_q, neg2_q;
  qrs_pkg::case_e case_p2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm1_q     <= n1_q[NW-1] ? MW'(-n1_q) : MW'(n1_q);
      nm2_q     <= n2_q[NW-1] ? MW'(-n2_q) : MW'(n2_q);
      dm1_q     <= d1_q[DNW-1] ? DMW'(-d1_q) : DMW'(d1_q);
      dm2_q     <= d2_q[DNW-1] ? DMW'(-d2_q) : DMW'(d2_q);
      neg1_q    <= n1_q[NW-1] ^ d1_q[DNW-1];
      neg2_q    <= n2_q[NW-1] ^ d2_q[DNW-1];
      case_p2_q <= case_p1_q;
    end
  end

  // ------------------------------------------------------ divider chains
  logic [DMW-1:0]    dv1_rem [QW+1];
  logic [QW-1:0]     dv1_x   [QW+1];
  logic [DMW-1:0]    dv1_den [QW+1];
  logic [TAG1_W-1:0] dv1_tag [QW+1];
  logic [DMW-1:0]    dv2_rem [QW+1];
  logic [QW-1:0]     dv2_x   [QW+1];
  logic [DMW-1:0]    dv2_den [QW+1];
  logic              dv2_tag [QW+1];

  assign dv1_rem[0] = '0;
  assign dv1_x[0]   = {nm1_q, {F{1'b0}}};
  assign dv1_den[0] = dm1_q;
  assign dv1_tag[0] = {case_p2_q, neg1_q};
  assign dv2_rem[0] = '0;
  assign dv2_x[0]   = {nm2_q, {F{1'b0}}};
  assign dv2_den[0] = dm2_q;
  assign dv2_tag[0] = neg2_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qrs_div_cell #(
      .DEN_W (DMW),
      .QW    (QW),
      .TAG_W (TAG1_W)
    ) u_first (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (dv1_rem[k]),
      .x_i   (dv1_x[k]),
      .den_i (dv1_den[k]),
      .tag_i (dv1_tag[k]),
      .rem_o (dv1_rem[k+1]),
      .x_o   (dv1_x[k+1]),
      .den_o (dv1_den[k+1]),
      .tag_o (dv1_tag[k+1])
    );

    qrs_div_cell #(
      .DEN_W (DMW),
      .QW    (QW),
      .TAG_W (1)
    ) u_second (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (dv2_rem[k]),
      .x_i   (dv2_x[k]),
      .den_i (dv2_den[k]),
      .tag_i (dv2_tag[k]),
      .rem_o (dv2_rem[k+1]),
      .x_o   (dv2_x[k+1]),
      .den_o (dv2_den[k+1]),
      .tag_o (dv2_tag[k+1])
    );
  end

  // ----------------------------------------- clamp, sign and register out
  function automatic logic [W:0] fix_root(logic [QW-1:0] q, logic neg);
    logic [W-1:0] lim;
    logic [W-1:0] qm;
    logic         over;
    lim  = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    over = q > QW'(lim);
    qm   = over ? lim : q[W-1:0];
    return {over, neg ? (W'(0) - qm) : qm};
  endfunction

  qrs_pkg::case_e      fcase;
  logic [W:0]          fr1, fr2;
  logic                use1, use2;
  qrs_pkg::kind_e      kind_q;
  logic signed [W-1:0] r1_q, r2_q;
  logic                sat_q;

  assign fcase = qrs_pkg::case_e'(dv1_tag[QW][3:1]);
  assign fr1   = fix_root(dv1_x[QW], dv1_tag[QW][0]);
  assign fr2   = fix_root(dv2_x[QW], dv2_tag[QW]);
  assign use1  = qrs_pkg::use_first(fcase);
  assign use2  = qrs_pkg::use_second(fcase);

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q <= qrs_pkg::kind_of(fcase);
      r1_q   <= use1 ? signed'(fr1[W-1:0]) : '0;
      r2_q   <= use2 ? signed'(fr2[W-1:0]) : '0;
      sat_q  <= (use1 && fr1[W]) || (use2 && fr2[W]);
    end
  end

  assign root_o.valid       = out_vld_q;
  assign root_o.root_kind   = kind_q;
  assign root_o.first_root  = r1_q;
  assign root_o.second_root = r2_q;
  assign root_o.saturated   = sat_q;

endmodule

// File: rtl/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle while en_i is high.
// Instantiated in a row by the top level; no package needed.
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
  parameter int SW    = 33,
  parameter int TAG_W = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SW:0]          rem_i,
  input  logic [SW-1:0]        root_i,
  input  logic [2*SW-1:0]      d_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic [SW:0]          rem_o,
  output logic [SW-1:0]        root_o,
  output logic [2*SW-1:0]      d_o,
  output logic [TAG_W-1:0]     tag_o
);
  localparam int RW = SW + 1;
  localparam int DW = 2 * SW;
  localparam int TW = RW + 2;

  logic [TW-1:0] part;
  logic [TW-1:0] trial;
  logic [TW-1:0] diff;
  logic          ge;

  // Bring down the next two radicand bits and try the next root bit
  assign part  = {rem_i, d_i[DW-1 -: 2]};
  assign trial = TW'({root_i, 2'b01});
  assign diff  = part - trial;
  assign ge    = part >= trial;

  // Advance to the neighbor cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[RW-1:0] : part[RW-1:0];
      root_o <= {root_i[SW-2:0], ge};
      d_o    <= {d_i[DW-3:0], 2'b00};
      tag_o  <= tag_i;
    end
  end

endmodule

// File: rtl/qrs_div_cell.sv
// One cell of a divider chain: one restoring quotient bit per cycle while en_i is high.
// Instantiated in a row by the top level; no package needed.
`timescale 1ns / 1ps

module qrs_div_cell #(
  parameter int DEN_W = 33,
  parameter int QW    = 50,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [QW-1:0]    x_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic [DEN_W-1:0] rem_o,
  output logic [QW-1:0]    x_o,
  output logic [DEN_W-1:0] den_o,
  output logic [TAG_W-1:0] tag_o
);
  logic [DEN_W:0] part;
  logic [DEN_W:0] diff;
  logic           ge;

  // Shift in the next dividend bit and compare against the divisor
  assign part = {rem_i, x_i[QW-1]};
  assign diff = part - {1'b0, den_i};
  assign ge   = part >= {1'b0, den_i};

  // Quotient bits enter at the bottom as dividend bits leave the top
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
      x_o   <= {x_i[QW-2:0], ge};
      den_o <= den_i;
      tag_o <= tag_i;
    end
  end

endmodule

// File: rtl/qrs_checker.sv
// Port-level checks of the quadratic root solver, bound to the top level.
// Uses qrs_pkg for the root count codes.
`timescale 1ns / 1ps

module qrs_checker #(
  parameter int W = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [1:0]   root_kind_i,
  input logic [W-1:0] first_root_i,
  input logic [W-1:0] second_root_i,
  input logic         saturated_i
);

  // A stalled result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(first_root_i) &&
    $stable(second_root_i) && $stable(root_kind_i) && $stable(saturated_i))
    else $error("stalled result changed");

  // A stalled output freezes the pipeline, so no request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while output stalled");

  // No root fields and no clamp when there is no finite root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (root_kind_i == qrs_pkg::KIND_NONE || root_kind_i == qrs_pkg::KIND_INF)
    |-> first_root_i == '0 && second_root_i == '0 && !saturated_i)
    else $error("root fields set without roots");

  // A single root leaves the second field clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && root_kind_i == qrs_pkg::KIND_ONE |-> second_root_i == '0)
    else $error("second root set for single root");

endmodule

bind quadratic_root_solver_unit qrs_checker #(
  .W (COEF_WIDTH)
) u_qrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (coef_i.ready),
  .out_valid_i   (root_o.valid),
  .out_ready_i   (root_o.ready),
  .root_kind_i   (root_o.root_kind),
  .first_root_i  (root_o.first_root),
  .second_root_i (root_o.second_root),
  .saturated_i   (root_o.saturated)
);
